>>> design/two_joint_linear_interpolator_defines.svh
// Assertion macros shared by the interpolator RTL.
`ifndef TWO_JOINT_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TWO_JOINT_LINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("interpolator assertion failed");
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("interpolator forbidden condition");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

>>> design/tjli_pkg.sv
// Types and fixed constants of the two-joint linear interpolator.
package tjli_pkg;

	localparam int ANGLE_W   = 18;
	localparam int LEAST_W   = 10;
	localparam int PULSE_W   = 12;
	localparam int DEG_W     = 8;
	localparam int DEG_LIMIT = 180;
	localparam int HOME_DEG  = 90;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;
	localparam int CFG_AW    = 4;
	localparam int CFG_DW    = 32;

	localparam logic [1:0] REG_PULSE_ZERO  = 2'd0;
	localparam logic [1:0] REG_PULSE_FULL  = 2'd1;
	localparam logic [1:0] REG_LEAST_STEPS = 2'd2;

	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef logic [PULSE_W-1:0] pulse_t;
	typedef logic [DEG_W-1:0]   deg_t;

	localparam pulse_t PULSE_ZERO_RST = 12'd800;
	localparam pulse_t PULSE_FULL_RST = 12'd2200;
	localparam logic [LEAST_W-1:0] LEAST_STEPS_RST = 10'd10;

	typedef struct packed {
		pulse_t shoulder_pulse;
		deg_t   elbow_degrees;
		logic   final_step;
	} result_t;

endpackage

>>> design/two_joint_linear_interpolator.sv
// Two-joint linear interpolator: bit-serial step generator for a shoulder/elbow servo arm.
// A move request (tuser low) sets new shoulder and elbow targets; it is
// dropped while a move is still in progress. Each tick request (tuser high) during a move yields
// one step: shoulder pulse width, elbow degrees, and tlast on the final step. No request is taken
// while a tick is being worked; the lanes hold NW + SW bits, where SW = clog2(MAX_STEPS+1)
// and NW = 18 angle bits (more when 90 << FRACTION_BITS needs them).
// A tick runs through the two bit-serial lanes (shift-add multiply by the step number, then
// a restoring divide by the step count, one bit per cycle) and through the serial pulse mapping
// (shift-add multiply, then restoring divide by 180). A finished step waits in an output register
// while the next request is taken; ticks while idle give no step.
`include "two_joint_linear_interpolator_defines.svh"

module two_joint_linear_interpolator
	import tjli_pkg::*;
#(
	parameter int FRACTION_BITS = 8,
	parameter int MAX_STEPS     = 1023
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [17:0] target_shoulder, [35:18] target_elbow
	input  logic                 s_tuser,   // [0] command
	// step stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] shoulder_pulse, [19:12] elbow_degrees
	output logic                 m_tlast,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [CFG_AW-1:0]    paddr,
	input  logic [CFG_DW-1:0]    pwdata,
	output logic [CFG_DW-1:0]    prdata,
	output logic                 pready
);

	localparam int SW     = $clog2(MAX_STEPS + 1);
	localparam int HOME   = HOME_DEG << FRACTION_BITS;
	localparam int HOME_W = $clog2(HOME + 1) + 1;
	localparam int NW     = (HOME_W > ANGLE_W) ? HOME_W : ANGLE_W;
	localparam int PW     = NW + SW;
	localparam int PPW    = PULSE_W + DEG_W;
	localparam int HALF   = (1 << FRACTION_BITS) >> 1;
	localparam int CW     = $clog2(PW + 1);
	localparam int PREM_W = $clog2(DEG_LIMIT);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MOVE_A = 4'd1;
	localparam logic [3:0] ST_MOVE_B = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_ANGLE  = 4'd5;
	localparam logic [3:0] ST_ROUND  = 4'd6;
	localparam logic [3:0] ST_PMUL   = 4'd7;
	localparam logic [3:0] ST_PDIV   = 4'd8;
	localparam logic [3:0] ST_EMIT   = 4'd9;

	logic [3:0]            state_q;
	logic [CW-1:0]         cnt_q;
	pulse_t                pz_q, pf_q;
	logic [LEAST_W-1:0]    least_q;
	logic [NW-1:0]         now_s_q, now_e_q, goal_s_q, goal_e_q;
	logic [SW-1:0]         total_q, idx_q, ish_q, rem_s_q, rem_e_q, floor_q;
	logic                  moving_q;
	logic [NW-1:0]         mag_s_q, mag_e_q;
	logic                  neg_s_q, neg_e_q;
	logic [PW-1:0]         acc_s_q, acc_e_q;
	logic [NW:0]           v_s_q, v_e_q;
	deg_t                  edeg_q, dsh_q;
	logic [PULSE_W-1:0]    pmag_q;
	logic                  pneg_q;
	logic [PPW-1:0]        pacc_q;
	logic [PREM_W-1:0]     prem_q;
	result_t               res_q;
	logic                  m_valid_q;

	logic                  s_acc, cfg_wr, emit_go;
	logic [NW-1:0]         ts_ext, te_ext;
	logic [NW:0]           dist_s, dist_e;
	logic [NW-1:0]         least_nw, floor_c, big, steps, steps_lo, steps_cap;
	logic [SW:0]           rsh_s, rsh_e, rdiff_s, rdiff_e;
	logic                  ge_s, ge_e;
	logic [NW:0]           q_s, q_e;
	logic [PULSE_W:0]      span;
	logic [PREM_W:0]       psh, pdiff;
	logic                  pge;
	logic [PULSE_W+1:0]    pq, pulse_w;
	logic [SW:0]           inext;
	logic                  last;

	function automatic logic [NW-1:0] mag_of(input logic [NW:0] d);
		logic [NW:0] n;
		n = -d;
		mag_of = d[NW] ? n[NW-1:0] : d[NW-1:0];
	endfunction

	// round half away from zero, then limit to 0..180
	function automatic deg_t to_deg(input logic [NW:0] v);
		logic [NW+1:0] r;
		r = ({1'b0, v} + (NW+2)'(HALF)) >> FRACTION_BITS;
		if (v[NW]) begin
			to_deg = '0;
		end else if (r > (NW+2)'(DEG_LIMIT)) begin
			to_deg = deg_t'(DEG_LIMIT);
		end else begin
			to_deg = r[DEG_W-1:0];
		end
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;

	assign ts_ext = NW'($signed(s_tdata[ANGLE_W-1:0]));
	assign te_ext = NW'($signed(s_tdata[2*ANGLE_W-1:ANGLE_W]));

	assign dist_s = {goal_s_q[NW-1], goal_s_q} - {now_s_q[NW-1], now_s_q};
	assign dist_e = {goal_e_q[NW-1], goal_e_q} - {now_e_q[NW-1], now_e_q};

	// step count: larger distance in whole degrees, floor from least_steps, cap at MAX_STEPS
	assign least_nw  = (least_q == '0) ? NW'(1) : NW'(least_q);
	assign floor_c   = (least_nw > NW'(MAX_STEPS)) ? NW'(MAX_STEPS) : least_nw;
	assign big       = (mag_s_q > mag_e_q) ? mag_s_q : mag_e_q;
	assign steps     = big >> FRACTION_BITS;
	assign steps_lo  = (steps < NW'(floor_q)) ? NW'(floor_q) : steps;
	assign steps_cap = (steps_lo > NW'(MAX_STEPS)) ? NW'(MAX_STEPS) : steps_lo;

	// restoring divide lanes by the step count
	assign rsh_s   = {rem_s_q, acc_s_q[PW-1]};
	assign rsh_e   = {rem_e_q, acc_e_q[PW-1]};
	assign rdiff_s = rsh_s - {1'b0, total_q};
	assign rdiff_e = rsh_e - {1'b0, total_q};
	assign ge_s    = (rsh_s >= {1'b0, total_q});
	assign ge_e    = (rsh_e >= {1'b0, total_q});

	assign q_s = {1'b0, acc_s_q[NW-1:0]};
	assign q_e = {1'b0, acc_e_q[NW-1:0]};

	assign span = {1'b0, pf_q} - {1'b0, pz_q};

	// restoring divide by 180 for the pulse mapping
	assign psh   = {prem_q, pacc_q[PPW-1]};
	assign pdiff = psh - (PREM_W+1)'(DEG_LIMIT);
	assign pge   = (psh >= (PREM_W+1)'(DEG_LIMIT));

	assign pq      = {2'b00, pacc_q[PULSE_W-1:0]};
	assign pulse_w = {2'b00, pz_q} + (pneg_q ? -pq : pq);

	assign inext = {1'b0, idx_q} + (SW+1)'(1);
	assign last  = (inext == {1'b0, total_q});

	// load the output register once it is free or being drained
	assign emit_go = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pz_q    <= PULSE_ZERO_RST;
			pf_q    <= PULSE_FULL_RST;
			least_q <= LEAST_STEPS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PULSE_ZERO:  pz_q    <= pwdata[PULSE_W-1:0];
				REG_PULSE_FULL:  pf_q    <= pwdata[PULSE_W-1:0];
				REG_LEAST_STEPS: least_q <= pwdata[LEAST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PULSE_ZERO:  prdata = CFG_DW'(pz_q);
			REG_PULSE_FULL:  prdata = CFG_DW'(pf_q);
			REG_LEAST_STEPS: prdata = CFG_DW'(least_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			now_s_q   <= NW'(HOME);
			now_e_q   <= NW'(HOME);
			goal_s_q  <= '0;
			goal_e_q  <= '0;
			total_q   <= '0;
			idx_q     <= '0;
			moving_q  <= 1'b0;
			m_valid_q <= 1'b0;
			ish_q     <= '0;
			rem_s_q   <= '0;
			rem_e_q   <= '0;
			floor_q   <= '0;
			mag_s_q   <= '0;
			mag_e_q   <= '0;
			neg_s_q   <= 1'b0;
			neg_e_q   <= 1'b0;
			acc_s_q   <= '0;
			acc_e_q   <= '0;
			v_s_q     <= '0;
			v_e_q     <= '0;
			edeg_q    <= '0;
			dsh_q     <= '0;
			pmag_q    <= '0;
			pneg_q    <= 1'b0;
			pacc_q    <= '0;
			prem_q    <= '0;
			res_q     <= '0;
		end else begin
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == CMD_MOVE) begin
							// drop a move that arrives mid-move
							if (!moving_q) begin
								goal_s_q <= ts_ext;
								goal_e_q <= te_ext;
								state_q  <= ST_MOVE_A;
							end
						end else if (moving_q) begin
							mag_s_q <= mag_of(dist_s);
							mag_e_q <= mag_of(dist_e);
							neg_s_q <= dist_s[NW];
							neg_e_q <= dist_e[NW];
							ish_q   <= inext[SW-1:0];
							acc_s_q <= '0;
							acc_e_q <= '0;
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MOVE_A: begin
					mag_s_q <= mag_of(dist_s);
					mag_e_q <= mag_of(dist_e);
					floor_q <= floor_c[SW-1:0];
					state_q <= ST_MOVE_B;
				end
				ST_MOVE_B: begin
					total_q  <= steps_cap[SW-1:0];
					idx_q    <= '0;
					moving_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_MUL: begin
					acc_s_q <= {acc_s_q[PW-2:0], 1'b0} + (ish_q[SW-1] ? PW'(mag_s_q) : '0);
					acc_e_q <= {acc_e_q[PW-2:0], 1'b0} + (ish_q[SW-1] ? PW'(mag_e_q) : '0);
					ish_q   <= {ish_q[SW-2:0], 1'b0};
					if (cnt_q == CW'(SW - 1)) begin
						cnt_q   <= '0;
						rem_s_q <= '0;
						rem_e_q <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DIV: begin
					rem_s_q <= ge_s ? rdiff_s[SW-1:0] : rsh_s[SW-1:0];
					rem_e_q <= ge_e ? rdiff_e[SW-1:0] : rsh_e[SW-1:0];
					acc_s_q <= {acc_s_q[PW-2:0], ge_s};
					acc_e_q <= {acc_e_q[PW-2:0], ge_e};
					if (cnt_q == CW'(PW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ANGLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_ANGLE: begin
					v_s_q   <= {now_s_q[NW-1], now_s_q} + (neg_s_q ? -q_s : q_s);
					v_e_q   <= {now_e_q[NW-1], now_e_q} + (neg_e_q ? -q_e : q_e);
					pneg_q  <= span[PULSE_W];
					pmag_q  <= span[PULSE_W] ? (-span[PULSE_W-1:0]) : span[PULSE_W-1:0];
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					dsh_q   <= to_deg(v_s_q);
					edeg_q  <= to_deg(v_e_q);
					pacc_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					pacc_q <= {pacc_q[PPW-2:0], 1'b0} + (dsh_q[DEG_W-1] ? PPW'(pmag_q) : '0);
					dsh_q  <= {dsh_q[DEG_W-2:0], 1'b0};
					if (cnt_q == CW'(DEG_W - 1)) begin
						cnt_q   <= '0;
						prem_q  <= '0;
						state_q <= ST_PDIV;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_PDIV: begin
					prem_q <= pge ? pdiff[PREM_W-1:0] : psh[PREM_W-1:0];
					pacc_q <= {pacc_q[PPW-2:0], pge};
					if (cnt_q == CW'(PPW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						res_q.shoulder_pulse <= pulse_w[PULSE_W-1:0];
						res_q.elbow_degrees  <= edeg_q;
						res_q.final_step     <= last;
						if (last) begin
							now_s_q  <= goal_s_q;
							now_e_q  <= goal_e_q;
							idx_q    <= '0;
							moving_q <= 1'b0;
						end else begin
							idx_q <= inext[SW-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, res_q.elbow_degrees, res_q.shoulder_pulse};
	assign m_tlast  = res_q.final_step;

	`ASSERT_CLK(a_idx_below_total, moving_q |-> (idx_q < total_q))
	`ASSERT_CLK(a_lane_rem_range, (state_q == ST_DIV) |-> ((rem_s_q < total_q) && (rem_e_q < total_q)))
	`ASSERT_CLK(a_pulse_rem_range, (state_q == ST_PDIV) |-> (prem_q < PREM_W'(DEG_LIMIT)))
	`ASSERT_NEVER(a_tick_without_move, (state_q == ST_MUL) && !moving_q)

endmodule
